/* src/m68kocd_pkg.sv */
// Package: rule table, widths and class codes for the opcode class decoder.
`default_nettype none
package m68kocd_pkg;
    localparam int RULE_COUNT  = 173;
    localparam int WORD_W      = 16;
    localparam int IDX_W       = 8;
    localparam int CLS_W       = 6;
    localparam int OP_W        = 6;
    localparam logic [CLS_W-1:0] CLS_INVALID = 6'd61;
    localparam logic [CLS_W-1:0] CLS_RET     = 6'd32;
    localparam logic [CLS_W-1:0] CLS_RETARG  = 6'd33;
    localparam logic [CLS_W-1:0] CLS_BRA     = 6'd44;
    localparam logic [OP_W-1:0]  OP_NONE     = 6'd0;

    typedef struct packed {
        logic [WORD_W-1:0] care;
        logic [WORD_W-1:0] want;
        logic [CLS_W-1:0]  cls;
        logic [OP_W-1:0]   op;
    } t_rule;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CLS_W-1:0] cls;
        logic [OP_W-1:0]  op;
        logic             valid;
        logic             ends;
    } t_dec;

    localparam t_rule RULES [RULE_COUNT] = '{
        '{16'hffff,16'h003c,6'd0,6'd0},'{16'hffff,16'h007c,6'd1,6'd0},
        '{16'hff00,16'h0000,6'd2,6'd1},
        '{16'hffff,16'h023c,6'd0,6'd0},'{16'hffff,16'h027c,6'd1,6'd0},
        '{16'hff00,16'h0200,6'd2,6'd2},
        '{16'hff00,16'h0400,6'd2,6'd3},'{16'hfff0,16'h06c0,6'd3,6'd0},
        '{16'hffc0,16'h06c0,6'd4,6'd0},'{16'hff00,16'h0600,6'd2,6'd4},
        '{16'hf9c0,16'h00c0,6'd5,6'd0},'{16'hffff,16'h0a3c,6'd0,6'd0},
        '{16'hffff,16'h0a7c,6'd1,6'd0},'{16'hff00,16'h0a00,6'd2,6'd5},
        '{16'hff00,16'h0c00,6'd2,6'd6},'{16'hffc0,16'h0800,6'd6,6'd0},
        '{16'hffc0,16'h0840,6'd6,6'd0},'{16'hffc0,16'h0880,6'd6,6'd0},
        '{16'hffc0,16'h08c0,6'd6,6'd0},
        '{16'hff00,16'h0e00,6'd7,6'd0},'{16'hf9ff,16'h08fc,6'd8,6'd0},
        '{16'hf9c0,16'h08c0,6'd9,6'd0},
        '{16'hf1c0,16'h0100,6'd10,6'd0},'{16'hf1c0,16'h0140,6'd10,6'd0},
        '{16'hf1c0,16'h0180,6'd10,6'd0},'{16'hf138,16'h0108,6'd11,6'd0},
        '{16'hf000,16'h1000,6'd12,6'd0},'{16'hf1c0,16'h2040,6'd13,6'd0},
        '{16'hf000,16'h2000,6'd13,6'd0},'{16'hf1c0,16'h3040,6'd14,6'd0},
        '{16'hf000,16'h3000,6'd14,6'd0},
        '{16'hffc0,16'h40c0,6'd15,6'd0},'{16'hffc0,16'h42c0,6'd16,6'd0},
        '{16'hff00,16'h4000,6'd17,6'd0},'{16'hff00,16'h4200,6'd17,6'd7},
        '{16'hffc0,16'h44c0,6'd18,6'd0},'{16'hff00,16'h4400,6'd17,6'd8},
        '{16'hffc0,16'h46c0,6'd19,6'd0},'{16'hff00,16'h4600,6'd17,6'd9},
        '{16'hffb8,16'h4880,6'd20,6'd10},'{16'hffb8,16'h4980,6'd20,6'd11},
        '{16'hfff8,16'h4808,6'd21,6'd0},'{16'hffc0,16'h4800,6'd22,6'd0},
        '{16'hfff8,16'h4840,6'd23,6'd0},'{16'hfff8,16'h4848,6'd24,6'd0},
        '{16'hffc0,16'h4840,6'd25,6'd0},
        '{16'hffff,16'h4afa,6'd26,6'd0},'{16'hffff,16'h4afc,6'd26,6'd0},
        '{16'hffc0,16'h4ac0,6'd22,6'd0},'{16'hff00,16'h4a00,6'd17,6'd12},
        '{16'hffc0,16'h4c00,6'd27,6'd13},'{16'hffc0,16'h4c40,6'd27,6'd14},
        '{16'hfff0,16'h4e40,6'd28,6'd0},'{16'hfff8,16'h4e50,6'd21,6'd0},
        '{16'hfff8,16'h4e58,6'd29,6'd0},'{16'hfff8,16'h4e60,6'd30,6'd0},
        '{16'hffff,16'h4e70,6'd26,6'd0},'{16'hffff,16'h4e71,6'd26,6'd0},
        '{16'hffff,16'h4e72,6'd31,6'd0},'{16'hffff,16'h4e73,6'd32,6'd0},
        '{16'hffff,16'h4e74,6'd33,6'd0},'{16'hffff,16'h4e75,6'd32,6'd15},
        '{16'hffff,16'h4e76,6'd26,6'd0},'{16'hffff,16'h4e77,6'd32,6'd0},
        '{16'hfffe,16'h4e7a,6'd34,6'd0},'{16'hffc0,16'h4e80,6'd22,6'd16},
        '{16'hffc0,16'h4ec0,6'd35,6'd0},'{16'hfb80,16'h4880,6'd36,6'd0},
        '{16'hf1c0,16'h41c0,6'd37,6'd0},'{16'hf040,16'h4040,6'd38,6'd0},
        '{16'hfff8,16'h50c8,6'd39,6'd0},'{16'hfff8,16'h51c8,6'd39,6'd0},
        '{16'hfff8,16'h52c8,6'd39,6'd0},'{16'hfff8,16'h53c8,6'd39,6'd0},
        '{16'hfff8,16'h54c8,6'd39,6'd0},'{16'hfff8,16'h55c8,6'd39,6'd0},
        '{16'hfff8,16'h56c8,6'd39,6'd0},'{16'hfff8,16'h57c8,6'd39,6'd0},
        '{16'hfff8,16'h58c8,6'd39,6'd0},'{16'hfff8,16'h59c8,6'd39,6'd0},
        '{16'hfff8,16'h5ac8,6'd39,6'd0},'{16'hfff8,16'h5bc8,6'd39,6'd0},
        '{16'hfff8,16'h5cc8,6'd39,6'd0},'{16'hfff8,16'h5dc8,6'd39,6'd0},
        '{16'hfff8,16'h5ec8,6'd39,6'd0},'{16'hfff8,16'h5fc8,6'd39,6'd0},
        '{16'hf0ff,16'h50fa,6'd40,6'd0},'{16'hf0ff,16'h50fb,6'd41,6'd0},
        '{16'hf0ff,16'h50fc,6'd26,6'd0},
        '{16'hffc0,16'h50c0,6'd42,6'd0},'{16'hffc0,16'h51c0,6'd42,6'd0},
        '{16'hffc0,16'h52c0,6'd42,6'd17},'{16'hffc0,16'h53c0,6'd42,6'd18},
        '{16'hffc0,16'h54c0,6'd42,6'd19},'{16'hffc0,16'h55c0,6'd42,6'd20},
        '{16'hffc0,16'h56c0,6'd42,6'd21},'{16'hffc0,16'h57c0,6'd42,6'd22},
        '{16'hffc0,16'h58c0,6'd42,6'd0},'{16'hffc0,16'h59c0,6'd42,6'd0},
        '{16'hffc0,16'h5ac0,6'd42,6'd0},'{16'hffc0,16'h5bc0,6'd42,6'd0},
        '{16'hffc0,16'h5cc0,6'd42,6'd23},'{16'hffc0,16'h5dc0,6'd42,6'd24},
        '{16'hffc0,16'h5ec0,6'd42,6'd25},'{16'hffc0,16'h5fc0,6'd42,6'd26},
        '{16'hf100,16'h5000,6'd43,6'd4},'{16'hf100,16'h5100,6'd43,6'd3},
        '{16'hff00,16'h6000,6'd44,6'd0},'{16'hff00,16'h6100,6'd45,6'd0},
        '{16'hff00,16'h6200,6'd45,6'd17},'{16'hff00,16'h6300,6'd45,6'd18},
        '{16'hff00,16'h6400,6'd45,6'd19},'{16'hff00,16'h6500,6'd45,6'd20},
        '{16'hff00,16'h6600,6'd45,6'd21},'{16'hff00,16'h6700,6'd45,6'd22},
        '{16'hff00,16'h6800,6'd45,6'd0},'{16'hff00,16'h6900,6'd45,6'd0},
        '{16'hff00,16'h6a00,6'd45,6'd0},'{16'hff00,16'h6b00,6'd45,6'd0},
        '{16'hff00,16'h6c00,6'd45,6'd23},'{16'hff00,16'h6d00,6'd45,6'd24},
        '{16'hff00,16'h6e00,6'd45,6'd25},'{16'hff00,16'h6f00,6'd45,6'd26},
        '{16'hf100,16'h7000,6'd46,6'd0},'{16'hf1c0,16'h80c0,6'd47,6'd27},
        '{16'hf1c0,16'h81c0,6'd47,6'd28},
        '{16'hf1f0,16'h8100,6'd48,6'd0},'{16'hf1f0,16'h8140,6'd49,6'd0},
        '{16'hf1f0,16'h8180,6'd49,6'd0},
        '{16'hf000,16'h8000,6'd50,6'd1},'{16'hf0c0,16'h90c0,6'd51,6'd3},
        '{16'hf130,16'h9100,6'd52,6'd0},'{16'hf000,16'h9000,6'd50,6'd3},
        '{16'hf000,16'ha000,6'd53,6'd0},
        '{16'hf0c0,16'hb0c0,6'd51,6'd6},'{16'hf138,16'hb108,6'd54,6'd0},
        '{16'hf100,16'hb000,6'd50,6'd6},'{16'hf000,16'hb000,6'd50,6'd5},
        '{16'hf1c0,16'hc0c0,6'd47,6'd29},'{16'hf1c0,16'hc1c0,6'd47,6'd30},
        '{16'hf1f0,16'hc100,6'd48,6'd0},
        '{16'hf1f8,16'hc140,6'd55,6'd0},'{16'hf1f8,16'hc148,6'd55,6'd0},
        '{16'hf1f8,16'hc188,6'd55,6'd0},
        '{16'hf000,16'hc000,6'd50,6'd2},'{16'hf0c0,16'hd0c0,6'd51,6'd4},
        '{16'hf130,16'hd100,6'd52,6'd0},'{16'hf000,16'hd000,6'd50,6'd4},
        '{16'hffc0,16'he0c0,6'd56,6'd31},'{16'hffc0,16'he1c0,6'd56,6'd32},
        '{16'hffc0,16'he2c0,6'd56,6'd33},'{16'hffc0,16'he3c0,6'd56,6'd32},
        '{16'hffc0,16'he4c0,6'd56,6'd0},'{16'hffc0,16'he5c0,6'd56,6'd0},
        '{16'hffc0,16'he6c0,6'd56,6'd0},'{16'hffc0,16'he7c0,6'd56,6'd0},
        '{16'hffc0,16'he8c0,6'd57,6'd0},'{16'hffc0,16'he9c0,6'd58,6'd0},
        '{16'hffc0,16'heac0,6'd57,6'd0},'{16'hffc0,16'hebc0,6'd58,6'd0},
        '{16'hffc0,16'hecc0,6'd57,6'd34},'{16'hffc0,16'hedc0,6'd58,6'd0},
        '{16'hffc0,16'heec0,6'd57,6'd35},'{16'hffc0,16'hefc0,6'd59,6'd0},
        '{16'hf118,16'he000,6'd60,6'd31},'{16'hf118,16'he100,6'd60,6'd32},
        '{16'hf118,16'he008,6'd60,6'd33},'{16'hf118,16'he108,6'd60,6'd32},
        '{16'hf118,16'he010,6'd60,6'd0},'{16'hf118,16'he110,6'd60,6'd0},
        '{16'hf118,16'he018,6'd60,6'd0},'{16'hf118,16'he118,6'd60,6'd0},
        '{16'hf000,16'hf000,6'd53,6'd0}
    };
endpackage
`default_nettype wire

/* src/m68k_opcode_class_decoder.sv */
// Top level: 68020 first opcode word class decoder.
// One request per cycle unless o_stall is high; the word is captured in an input
// register, matched against the 173-rule table and the answer held in a result
// register. The rule match is the only logic between the registers. A stall on the
// output is absorbed by a skid register, so the input stalls only when both the
// result and skid registers hold requests.
`default_nettype none
module m68k_opcode_class_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_instr_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_entry_index,
    output logic [5:0]       o_operand_class,
    output logic [5:0]       o_expr_op,
    output logic             o_is_valid,
    output logic             o_ends_block
);
    logic                               r_in_v;
    logic [m68kocd_pkg::WORD_W-1:0]     r_word;
    logic                               r_out_v;
    m68kocd_pkg::t_dec                  r_out;
    logic                               r_skid_v;
    m68kocd_pkg::t_dec                  r_skid;
    m68kocd_pkg::t_dec                  dec;
    logic                               out_take;
    logic                               in_take;
    logic                               mid_move;

    m68kocd_match u_match (.i_word(r_word), .o_dec(dec));

    assign out_take = r_out_v && !i_stall;
    // middle stage advances if the output slot frees up or skid empty
    assign mid_move = r_in_v && (!r_out_v || out_take || !r_skid_v);
    assign o_stall  = r_skid_v;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            // input stage loads a taken word, else empties when the middle stage advances
            if (in_take) begin
                r_in_v <= 1'b1;
                r_word <= i_instr_word;
            end else if (mid_move) begin
                r_in_v <= 1'b0;
            end
            if (!r_out_v || out_take) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                    if (mid_move) begin
                        r_skid   <= dec;
                        r_skid_v <= 1'b1;
                    end
                end else begin
                    r_out_v <= mid_move;
                    r_out   <= dec;
                end
            end else if (mid_move) begin
                r_skid   <= dec;
                r_skid_v <= 1'b1;
            end
        end
    end

    assign o_valid         = r_out_v;
    assign o_entry_index   = r_out.idx;
    assign o_operand_class = r_out.cls;
    assign o_expr_op       = r_out.op;
    assign o_is_valid      = r_out.valid;
    assign o_ends_block    = r_out.ends;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid full with empty output");
    a_valid_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.valid |-> r_out.idx < 8'd173) else $error("bad index");
    a_invalid_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out.valid |-> r_out.cls == m68kocd_pkg::CLS_INVALID
        && !r_out.ends) else $error("invalid result fields");
    a_in_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_v && !r_skid_v |=> !(r_in_v && $stable(r_word)) || $past(in_take))
        else $error("input stage stuck");
endmodule
`default_nettype wire

/* src/m68kocd_match.sv */
// Priority match of one word against the rule table.
`default_nettype none
module m68kocd_match (
    input  wire logic [m68kocd_pkg::WORD_W-1:0] i_word,
    output m68kocd_pkg::t_dec                   o_dec
);
    logic [m68kocd_pkg::RULE_COUNT-1:0] hit;

    always_comb begin
        for (int i = 0; i < m68kocd_pkg::RULE_COUNT; i++) begin
            hit[i] = (i_word & m68kocd_pkg::RULES[i].care) == m68kocd_pkg::RULES[i].want;
        end
    end

    // lowest-index matching rule wins: scan from the back
    always_comb begin
        o_dec.idx   = m68kocd_pkg::IDX_W'(m68kocd_pkg::RULE_COUNT);
        o_dec.cls   = m68kocd_pkg::CLS_INVALID;
        o_dec.op    = m68kocd_pkg::OP_NONE;
        o_dec.valid = 1'b0;
        for (int i = m68kocd_pkg::RULE_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_dec.idx   = m68kocd_pkg::IDX_W'(i);
                o_dec.cls   = m68kocd_pkg::RULES[i].cls;
                o_dec.op    = m68kocd_pkg::RULES[i].op;
                o_dec.valid = 1'b1;
            end
        end
        o_dec.ends = (o_dec.cls == m68kocd_pkg::CLS_RET) ||
                     (o_dec.cls == m68kocd_pkg::CLS_RETARG) ||
                     (o_dec.cls == m68kocd_pkg::CLS_BRA);
    end
endmodule
`default_nettype wire
